FILE: rtl/lpart_pkg.sv
// Shared constants and types for the linear partition min-max load block.
package lpart_pkg;

    localparam int MAX_BOOKS = 64;
    localparam int PAGE_BITS = 24;
    localparam int LOAD_W    = 30;
    localparam int RUN_W     = LOAD_W + 1;
    localparam int ADDR_W    = $clog2(MAX_BOOKS);
    localparam int CNT_W     = $clog2(MAX_BOOKS + 1);
    localparam int SCRIBE_W  = 7;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 56;
    localparam int OUT_USER_W = 2;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_MID,
        ST_SCAN,
        ST_UPDATE,
        ST_PART,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

endpackage

FILE: rtl/linear_partition_min_max_load.sv
// Top level of the linear partition min-max load block.
//
// Jobs stream in one per cycle and are stored, up to MAX_BOOKS of them; extra jobs are
// dropped and flagged on every result of the run. The job that carries tlast starts the
// solve, and the input stays not ready until all results have been handed to the output
// register. The solve binary-searches the bound between the largest job and the total:
// in each round one shared add and compare walks the job memory one entry per cycle
// over the n stored jobs, and there are up to about 30 rounds (log2 of total minus
// largest job). Group boundaries are then placed from the right, and the results go
// out in load order, each read from memory and then loaded into the output register,
// which holds while m_tready is low. num_scribes of zero acts as one; the user must write
// the register only while the block is idle; the block itself does not enforce this.
module linear_partition_min_max_load (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration: num_scribes
    input  logic                            cfg_we,
    input  logic [lpart_pkg::SCRIBE_W-1:0]  cfg_wdata,
    // input requests
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lpart_pkg::IN_DATA_W-1:0] s_tdata,  // [23:0] page_count
    input  logic                            s_tlast,  // last_book
    // result requests
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lpart_pkg::OUT_DATA_W-1:0] m_tdata, // [23:0] book_pages, [53:24] best_load,
                                                      // [55:54] zero
    output logic [lpart_pkg::OUT_USER_W-1:0] m_tuser, // [0] group_end, [1] overflowed
    output logic                            m_tlast   // last_result
);

    localparam int MAXB = lpart_pkg::MAX_BOOKS;
    localparam int PW   = lpart_pkg::PAGE_BITS;
    localparam int LW   = lpart_pkg::LOAD_W;
    localparam int RW   = lpart_pkg::RUN_W;
    localparam int AW   = lpart_pkg::ADDR_W;
    localparam int CW   = lpart_pkg::CNT_W;
    localparam int SW   = lpart_pkg::SCRIBE_W;

    // control registers
    lpart_pkg::state_t state_reg, state_next;
    logic [SW-1:0] num_scribes_reg, num_scribes_next;
    logic [CW-1:0] count_reg, count_next;
    logic [LW-1:0] total_reg, total_next;
    logic [PW-1:0] largest_reg, largest_next;
    logic          drop_reg, drop_next;
    logic [LW-1:0] low_reg, low_next;
    logic [LW-1:0] high_reg, high_next;
    logic [SW-1:0] k_reg, k_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          pend_reg, pend_next;
    logic [CW-1:0] groups_reg, groups_next;
    logic [SW-1:0] slashes_reg, slashes_next;
    logic          out_valid_reg, out_valid_next;

    // datapath registers
    logic [LW-1:0] mid_reg, mid_next;
    logic [RW-1:0] run_reg, run_next;
    logic [AW-1:0] pend_idx_reg, pend_idx_next;
    logic [PW-1:0] out_pages_reg, out_pages_next;
    logic [LW-1:0] out_load_reg, out_load_next;
    logic          out_end_reg, out_end_next;
    logic          out_ovf_reg, out_ovf_next;
    logic          out_last_reg, out_last_next;

    // memories
    logic [PW-1:0] job_mem [MAXB];
    logic          mark_mem [MAXB];
    logic [PW-1:0] job_rd_reg;
    logic          mark_rd_reg;
    logic          job_we;
    logic          mark_we;
    logic          mark_wdata;
    logic [AW-1:0] mark_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    // shared unit
    logic [RW-1:0] run_sum;
    logic [RW-1:0] bound;
    logic          over;
    logic [LW-1:0] half_span;
    logic [PW-1:0] page_in;
    logic          emit_last;
    logic          mark_bit;

    assign page_in   = s_tdata[PW-1:0];
    assign run_sum   = run_reg + RW'(job_rd_reg);
    assign bound     = (state_reg == lpart_pkg::ST_SCAN) ? RW'(mid_reg) : RW'(low_reg);
    assign over      = run_sum > bound;
    assign half_span = (high_reg - low_reg) >> 1;
    assign emit_last = (idx_reg + CW'(1)) == count_reg;
    assign mark_bit  = ((CW'(pend_idx_reg) + CW'(1)) < count_reg) && (slashes_reg != '0)
                       && (over || (slashes_reg > SW'(pend_idx_reg)));

    // drive ports
    assign s_tready = (state_reg == lpart_pkg::ST_LOAD);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(lpart_pkg::OUT_DATA_W - LW - PW){1'b0}}, out_load_reg, out_pages_reg};
    assign m_tuser  = {out_ovf_reg, out_end_reg};
    assign m_tlast  = out_last_reg;

    // sequence the load, search, partition and emit phases
    always_comb
    begin
        state_next       = state_reg;
        num_scribes_next = cfg_we ? cfg_wdata : num_scribes_reg;
        count_next       = count_reg;
        total_next       = total_reg;
        largest_next     = largest_reg;
        drop_next        = drop_reg;
        low_next         = low_reg;
        high_next        = high_reg;
        k_next           = k_reg;
        idx_next         = idx_reg;
        pend_next        = pend_reg;
        groups_next      = groups_reg;
        slashes_next     = slashes_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        mid_next         = mid_reg;
        run_next         = run_reg;
        pend_idx_next    = pend_idx_reg;
        out_pages_next   = out_pages_reg;
        out_load_next    = out_load_reg;
        out_end_next     = out_end_reg;
        out_ovf_next     = out_ovf_reg;
        out_last_next    = out_last_reg;
        job_we           = 1'b0;
        mark_we          = 1'b0;
        mark_wdata       = 1'b0;
        mark_addr        = pend_idx_reg;
        rd_en            = 1'b0;
        rd_addr          = idx_reg[AW-1:0];

        case (state_reg)
            lpart_pkg::ST_LOAD:
            begin
                if (s_tvalid)
                begin
                    // store the job, or drop it when the store is full
                    if (count_reg < CW'(MAXB))
                    begin
                        job_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                        total_next = total_reg + LW'(page_in);
                        if (page_in > largest_reg)
                            largest_next = page_in;
                    end
                    else
                        drop_next = 1'b1;
                    if (s_tlast)
                        state_next = lpart_pkg::ST_INIT;
                end
            end
            lpart_pkg::ST_INIT:
            begin
                low_next   = LW'(largest_reg);
                high_next  = total_reg;
                k_next     = (num_scribes_reg == '0) ? SW'(1) : num_scribes_reg;
                state_next = lpart_pkg::ST_MID;
            end
            lpart_pkg::ST_MID:
            begin
                pend_next = 1'b0;
                run_next  = '0;
                if (low_reg < high_reg)
                begin
                    // start a greedy round at the midpoint bound
                    mid_next    = low_reg + half_span;
                    idx_next    = '0;
                    groups_next = CW'(1);
                    state_next  = lpart_pkg::ST_SCAN;
                end
                else
                begin
                    // bound settled: place boundaries from the right
                    idx_next     = count_reg;
                    slashes_next = k_reg - SW'(1);
                    state_next   = lpart_pkg::ST_PART;
                end
            end
            lpart_pkg::ST_SCAN:
            begin
                pend_next = 1'b0;
                if (idx_reg < count_reg)
                begin
                    rd_en     = 1'b1;
                    idx_next  = idx_reg + CW'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    if (over)
                    begin
                        groups_next = groups_reg + CW'(1);
                        run_next    = RW'(job_rd_reg);
                    end
                    else
                        run_next = run_sum;
                end
                if ((idx_reg == count_reg) && !pend_reg)
                    state_next = lpart_pkg::ST_UPDATE;
            end
            lpart_pkg::ST_UPDATE:
            begin
                // narrow the search range
                if (groups_reg <= CW'(k_reg))
                    high_next = mid_reg;
                else
                    low_next = mid_reg + LW'(1);
                state_next = lpart_pkg::ST_MID;
            end
            lpart_pkg::ST_PART:
            begin
                pend_next = 1'b0;
                if (idx_reg != '0)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = AW'(idx_reg - CW'(1));
                    idx_next      = idx_reg - CW'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = AW'(idx_reg - CW'(1));
                end
                if (pend_reg)
                begin
                    mark_we    = 1'b1;
                    mark_wdata = mark_bit;
                    if (mark_bit)
                    begin
                        slashes_next = slashes_reg - SW'(1);
                        run_next     = RW'(job_rd_reg);
                    end
                    else
                        run_next = run_sum;
                end
                if ((idx_reg == '0) && !pend_reg)
                    state_next = lpart_pkg::ST_EMIT_RD;
            end
            lpart_pkg::ST_EMIT_RD:
            begin
                rd_en      = 1'b1;
                state_next = lpart_pkg::ST_EMIT_LD;
            end
            lpart_pkg::ST_EMIT_LD:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_pages_next = job_rd_reg;
                    out_load_next  = low_reg;
                    out_end_next   = mark_rd_reg && !emit_last;
                    out_ovf_next   = drop_reg;
                    out_last_next  = emit_last;
                    idx_next       = idx_reg + CW'(1);
                    if (emit_last)
                    begin
                        count_next   = '0;
                        total_next   = '0;
                        largest_next = '0;
                        low_next     = '0;
                        high_next    = '0;
                        drop_next    = 1'b0;
                        state_next   = lpart_pkg::ST_LOAD;
                    end
                    else
                        state_next = lpart_pkg::ST_EMIT_RD;
                end
            end
            default:
                state_next = lpart_pkg::ST_LOAD;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= lpart_pkg::ST_LOAD;
            num_scribes_reg <= SW'(1);
            count_reg       <= '0;
            total_reg       <= '0;
            largest_reg     <= '0;
            drop_reg        <= 1'b0;
            low_reg         <= '0;
            high_reg        <= '0;
            k_reg           <= SW'(1);
            idx_reg         <= '0;
            pend_reg        <= 1'b0;
            groups_reg      <= '0;
            slashes_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            num_scribes_reg <= num_scribes_next;
            count_reg       <= count_next;
            total_reg       <= total_next;
            largest_reg     <= largest_next;
            drop_reg        <= drop_next;
            low_reg         <= low_next;
            high_reg        <= high_next;
            k_reg           <= k_next;
            idx_reg         <= idx_next;
            pend_reg        <= pend_next;
            groups_reg      <= groups_next;
            slashes_reg     <= slashes_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        mid_reg       <= mid_next;
        run_reg       <= run_next;
        pend_idx_reg  <= pend_idx_next;
        out_pages_reg <= out_pages_next;
        out_load_reg  <= out_load_next;
        out_end_reg   <= out_end_next;
        out_ovf_reg   <= out_ovf_next;
        out_last_reg  <= out_last_next;
    end

    // job memory: write on load, registered read
    always_ff @(posedge clk)
    begin
        if (job_we)
            job_mem[count_reg[AW-1:0]] <= page_in;
        if (rd_en)
            job_rd_reg <= job_mem[rd_addr];
    end

    // boundary mark memory: write during partition, registered read
    always_ff @(posedge clk)
    begin
        if (mark_we)
            mark_mem[mark_addr] <= mark_wdata;
        if (rd_en)
            mark_rd_reg <= mark_mem[rd_addr];
    end

endmodule
